### hdl/acr_pkg.sv
// Shared types and constants for the associative cache replacement block.
// Holds field widths, register indexes, policy codes and the
// controller/datapath command and status structs. No dependencies.
package acr_pkg;

  // Default sizing, handed down from the top level
  localparam int WAYS_DEF     = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int AGE_BITS_DEF = 16;

  // Fixed port field widths
  localparam int KEY_W      = 16;
  localparam int WAY_W      = 4;
  localparam int TOTAL_W    = 32;
  localparam int POLICY_W   = 2;
  localparam int WIU_W      = 5;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Replacement policy codes; the unused code behaves as LRU
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_MRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RAND = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  // Reset values and LFSR feedback
  localparam logic [WIU_W-1:0]  WIU_RESET  = 5'd16;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  // Controller to datapath commands
  typedef struct packed {
    logic load_key;
    logic age_step;
    logic count;
    logic commit_direct;
    logic scan_start;
    logic scan_step;
    logic rand_start;
    logic take_rem;
    logic commit_victim;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic empty;
    logic rand_pol;
    logic scan_last;
    logic rem_done;
  } sts_t;

endpackage

### hdl/acr_urem.sv
// Bit-serial unsigned remainder unit, one dividend bit per cycle.
// Used to reduce the LFSR value modulo the ways in use. Depends on nothing.
module acr_urem #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  // Shift in the next dividend bit and subtract the divisor if it fits
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = (shifted >= {1'b0, den_i});
    rem_d   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/acr_dpath.sv
// Datapath of the cache directory: tags, valid bits, ages, config registers,
// LFSR, victim scan, hit and miss totals and the output register.
// Depends on acr_pkg and acr_urem.
module acr_dpath #(
  parameter int WAYS     = acr_pkg::WAYS_DEF,
  parameter int KEY_BITS = acr_pkg::KEY_BITS_DEF,
  parameter int AGE_BITS = acr_pkg::AGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  acr_pkg::cmd_t                   cmd_i,
  output acr_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [acr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [acr_pkg::KEY_W-1:0]       key_i,
  output logic                            hit_o,
  output logic [acr_pkg::WAY_W-1:0]       way_o,
  output logic                            evicted_o,
  output logic [acr_pkg::KEY_W-1:0]       evicted_key_o,
  output logic [acr_pkg::TOTAL_W-1:0]     hit_total_o,
  output logic [acr_pkg::TOTAL_W-1:0]     miss_total_o
);
  import acr_pkg::*;

  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Configuration and LFSR
  logic [POLICY_W-1:0] policy_q;
  logic [WIU_W-1:0]    wiu_q;
  logic [LFSR_W-1:0]   lfsr_q;
  logic [LFSR_W-1:0]   lfsr_nxt;

  // Directory storage
  logic [KEY_BITS-1:0] tag_q   [WAYS];
  logic [AGE_BITS-1:0] age_q   [WAYS];
  logic [WAYS-1:0]     valid_q;
  logic [KEY_BITS-1:0] key_q;

  // Lookup
  logic [CNT_W-1:0] n_eff;
  logic [WAYS-1:0]  in_use;
  logic             hit;
  logic             empty;
  logic [IDX_W-1:0] hit_way;
  logic [IDX_W-1:0] empty_way;
  logic [IDX_W-1:0] dir_way;

  // Victim scan
  logic [IDX_W-1:0]    scan_idx_q;
  logic [IDX_W-1:0]    vict_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [AGE_BITS-1:0] scan_age;
  logic                lru;
  logic                take;
  logic                rem_done;
  logic [CNT_W-1:0]    rem;

  // Write port
  logic             wr_fill;
  logic             wr_clear;
  logic [IDX_W-1:0] wr_way;

  // Totals and results
  logic [TOTAL_W-1:0] hits_q;
  logic [TOTAL_W-1:0] misses_q;
  logic               res_hit_q;
  logic [IDX_W-1:0]   res_way_q;
  logic               res_ev_q;
  logic [KEY_W-1:0]   res_evkey_q;
  logic               o_hit_q;
  logic [WAY_W-1:0]   o_way_q;
  logic               o_ev_q;
  logic [KEY_W-1:0]   o_evkey_q;
  logic [TOTAL_W-1:0] o_hits_q;
  logic [TOTAL_W-1:0] o_misses_q;

  // Advance the Galois LFSR by one step
  assign lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

  // Take config writes; a zero seed loads one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
      wiu_q    <= WIU_RESET;
      lfsr_q   <= SEED_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_POLICY: policy_q <= cfg_data_i[POLICY_W-1:0];
          CFG_WAYS:   wiu_q    <= cfg_data_i[WIU_W-1:0];
          default:    ;
        endcase
      end
      // Step the LFSR for a random pick, else load a written seed
      if (cmd_i.rand_start) begin
        lfsr_q <= lfsr_nxt;
      end else if (cfg_we_i && (cfg_index_i == CFG_SEED)) begin
        lfsr_q <= (cfg_data_i == '0) ? SEED_RESET : cfg_data_i;
      end
    end
  end

  // Clamp ways in use to 1..WAYS
  always_comb begin
    if (wiu_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(wiu_q) > 32'(WAYS)) begin
      n_eff = CNT_W'(WAYS);
    end else begin
      n_eff = CNT_W'(wiu_q);
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_use[i] = (CNT_W'(i) < n_eff);
    end
  end

  // Hold the key of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= KEY_BITS'(key_i);
    end
  end

  // Parallel tag match and empty-way search, lowest index wins
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && valid_q[i] && (tag_q[i] == key_q)) begin
        hit     = 1'b1;
        hit_way = IDX_W'(i);
      end
      if (in_use[i] && !valid_q[i]) begin
        empty     = 1'b1;
        empty_way = IDX_W'(i);
      end
    end
  end

  assign dir_way = hit ? hit_way : empty_way;

  // Scan one way per cycle for the oldest or youngest age
  assign scan_age = age_q[scan_idx_q];
  assign lru      = (policy_q != POL_MRU);
  assign take     = (scan_idx_q == '0) ||
                    (lru ? (scan_age > best_age_q) : (scan_age < best_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      vict_q     <= '0;
      best_age_q <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        if (take) begin
          vict_q     <= scan_idx_q;
          best_age_q <= scan_age;
        end
      end else if (cmd_i.take_rem) begin
        vict_q <= IDX_W'(rem);
      end
    end
  end

  // Reduce the fresh LFSR value modulo the ways in use
  acr_urem #(
    .NUM_W (LFSR_W),
    .DEN_W (CNT_W)
  ) u_urem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.rand_start),
    .num_i   (lfsr_nxt),
    .den_i   (n_eff),
    .done_o  (rem_done),
    .rem_o   (rem)
  );

  // Select the way written on this access
  assign wr_fill  = (cmd_i.commit_direct && !hit) || cmd_i.commit_victim;
  assign wr_clear = cmd_i.commit_direct || cmd_i.commit_victim;
  assign wr_way   = cmd_i.commit_victim ? vict_q : dir_way;

  always_ff @(posedge clk_i) begin
    if (wr_fill) begin
      tag_q[wr_way] <= key_q;
    end
  end

  // Age valid ways in use, clear the touched way, mark filled ways valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < WAYS; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (wr_clear && (wr_way == IDX_W'(i))) begin
          age_q[i] <= '0;
        end else if (cmd_i.age_step && in_use[i] && valid_q[i] &&
                     (age_q[i] != AGE_MAX)) begin
          age_q[i] <= age_q[i] + AGE_BITS'(1);
        end
        if (wr_fill && (wr_way == IDX_W'(i))) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  // Saturating hit and miss totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.count) begin
      if (hit) begin
        if (hits_q != '1) begin
          hits_q <= hits_q + TOTAL_W'(1);
        end
      end else if (misses_q != '1) begin
        misses_q <= misses_q + TOTAL_W'(1);
      end
    end
  end

  // Capture the result of the access
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_direct) begin
      res_hit_q   <= hit;
      res_way_q   <= dir_way;
      res_ev_q    <= 1'b0;
      res_evkey_q <= '0;
    end else if (cmd_i.commit_victim) begin
      res_hit_q   <= 1'b0;
      res_way_q   <= vict_q;
      res_ev_q    <= 1'b1;
      res_evkey_q <= KEY_W'(tag_q[vict_q]);
    end
  end

  // Output register, loaded once the previous item has left
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_hit_q    <= res_hit_q;
      o_way_q    <= WAY_W'(res_way_q);
      o_ev_q     <= res_ev_q;
      o_evkey_q  <= res_evkey_q;
      o_hits_q   <= hits_q;
      o_misses_q <= misses_q;
    end
  end

  assign hit_o         = o_hit_q;
  assign way_o         = o_way_q;
  assign evicted_o     = o_ev_q;
  assign evicted_key_o = o_evkey_q;
  assign hit_total_o   = o_hits_q;
  assign miss_total_o  = o_misses_q;

  // Status toward the controller
  always_comb begin
    sts_o           = '0;
    sts_o.hit       = hit;
    sts_o.empty     = empty;
    sts_o.rand_pol  = (policy_q == POL_RAND);
    sts_o.scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == n_eff);
    sts_o.rem_done  = rem_done;
  end

endmodule

### hdl/acr_ctrl.sv
// Controller state machine of the cache directory: sequences lookup,
// victim scan or random pick, commit and result handoff. Depends on acr_pkg.
module acr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  acr_pkg::sts_t sts_i,
  output acr_pkg::cmd_t cmd_o
);
  import acr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AGE    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = S_AGE;
        end
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        cmd_o.count    = 1'b1;
        if (sts_i.hit || sts_i.empty) begin
          cmd_o.commit_direct = 1'b1;
          state_d             = S_OUT;
        end else if (sts_i.rand_pol) begin
          cmd_o.rand_start = 1'b1;
          state_d          = S_DIV;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_DIV: begin
        if (sts_i.rem_done) begin
          cmd_o.take_rem = 1'b1;
          state_d        = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit_victim = 1'b1;
        state_d             = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            cmd_o.load_key = 1'b1;
            state_d        = S_AGE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/assoc_cache_replacement_top.sv
// A hit or a fill of an empty way commits in the lookup state itself; a
// full-cache miss first scans the ways under LRU or MRU (one age compare per
// way in use) or waits under random replacement for the 16-step bit-serial
// remainder of the LFSR value. One item is in flight at a time. Reset
// empties the directory, zeroes the totals and loads the config defaults and
// LFSR seed at once; no clearing pass.
module assoc_cache_replacement_top #(
  parameter int WAYS     = acr_pkg::WAYS_DEF,
  parameter int KEY_BITS = acr_pkg::KEY_BITS_DEF,
  parameter int AGE_BITS = acr_pkg::AGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [acr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [acr_pkg::KEY_W-1:0]       key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [acr_pkg::WAY_W-1:0]       way_o,
  output logic                            evicted_o,
  output logic [acr_pkg::KEY_W-1:0]       evicted_key_o,
  output logic [acr_pkg::TOTAL_W-1:0]     hit_total_o,
  output logic [acr_pkg::TOTAL_W-1:0]     miss_total_o
);
  import acr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  acr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acr_dpath #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .key_i         (key_i),
    .hit_o         (hit_o),
    .way_o         (way_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o)
  );

endmodule

### hdl/acr_checker.sv
// Port-level checks for the cache directory top level, bound in below.
// Depends on acr_pkg and assoc_cache_replacement_top.
module acr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [acr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [acr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [acr_pkg::KEY_W-1:0]       key_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            hit_o,
  input logic [acr_pkg::WAY_W-1:0]       way_o,
  input logic                            evicted_o,
  input logic [acr_pkg::KEY_W-1:0]       evicted_key_o,
  input logic [acr_pkg::TOTAL_W-1:0]     hit_total_o,
  input logic [acr_pkg::TOTAL_W-1:0]     miss_total_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(way_o) && $stable(hit_total_o))
    else $error("stalled result changed");

  // Drop ready while an accepted item is being looked up
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken during lookup");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit reported with eviction");

  // Evicted key reads zero without an eviction
  a_evkey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_key_o == '0)
    else $error("evicted key nonzero without eviction");

  // The total of the reported kind includes this access
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o ? (hit_total_o != '0) : (miss_total_o != '0)))
    else $error("total does not count this access");

endmodule

bind assoc_cache_replacement_top acr_checker u_acr_checker (.*);

### tb/assoc_cache_replacement_top_tb.sv
// Self-checking testbench for assoc_cache_replacement_top: directed and random
// key lookups over valid/ready, checked against a shadow cache directory.
// Depends on acr_pkg and the block's RTL only.
module assoc_cache_replacement_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acr_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 10;
  localparam int WAYS           = WAYS_DEF;
  localparam int AGE_MAX        = (1 << AGE_BITS_DEF) - 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int POOL_SIZE      = 40;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  // Codes the package leaves unnamed
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [POLICY_W-1:0]  POL_UNUSED = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } lookup_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_POLICY;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [KEY_W-1:0]      key_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [WAY_W-1:0]      way_o;
  logic                  evicted_o;
  logic [KEY_W-1:0]      evicted_key_o;
  logic [TOTAL_W-1:0]    hit_total_o;
  logic [TOTAL_W-1:0]    miss_total_o;

  assoc_cache_replacement_top uut (.*);

  // Free-running clock
  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Shadow copy of the registers and the directory
  logic [POLICY_W-1:0] pol_reg    = POL_LRU;
  logic [WIU_W-1:0]    ways_reg   = WIU_RESET;
  logic [LFSR_W-1:0]   rng_state  = SEED_RESET;
  logic [KEY_W-1:0]    dir_tag   [WAYS] = '{default: '0};
  bit                  dir_valid [WAYS] = '{default: 1'b0};
  int unsigned         dir_age   [WAYS] = '{default: 0};
  logic [TOTAL_W-1:0]  hit_count  = '0;
  logic [TOTAL_W-1:0]  miss_count = '0;

  lookup_result_t pending_lookups[$];
  int err_count      = 0;
  int lookups_done   = 0;
  int hits_done      = 0;
  int evictions_done = 0;
  int reg_writes     = 0;

  // Sender burst control and receiver stall control
  bit src_gaps_on    = 1'b0;
  int burst_left     = 1;
  bit sink_stalls_on = 1'b1;
  bit sink_open      = 1'b1;
  int sink_run       = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;

  function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_POLICY: pol_reg = data[POLICY_W-1:0];
      CFG_WAYS:   ways_reg = data[WIU_W-1:0];
      CFG_SEED:   rng_state = (data == '0) ? SEED_RESET : data;
      default: ;
    endcase
  endfunction

  // Advance the shadow directory by one access and return its result
  function automatic lookup_result_t predict_lookup(input logic [KEY_W-1:0] key);
    lookup_result_t r;
    int unsigned n;
    int unsigned w;
    int unsigned i;
    bit matched;
    bit placed;
    r = '0;
    w = 0;
    matched = 1'b0;
    placed = 1'b0;
    n = (ways_reg == '0) ? 1 : ((32'(ways_reg) > WAYS) ? WAYS : 32'(ways_reg));
    // age every valid way in use, saturating
    for (i = 0; i < n; i++)
      if (dir_valid[i] && dir_age[i] < AGE_MAX) dir_age[i]++;
    // lowest matching way hits
    for (i = 0; i < n; i++) begin
      if (!matched && dir_valid[i] && dir_tag[i] == key) begin
        matched = 1'b1;
        w = i;
      end
    end
    if (matched) begin
      dir_age[w] = 0;
      if (hit_count != '1) hit_count++;
    end else begin
      if (miss_count != '1) miss_count++;
      // fill the lowest empty way first
      for (i = 0; i < n; i++) begin
        if (!placed && !dir_valid[i]) begin
          placed = 1'b1;
          w = i;
        end
      end
      if (!placed) begin
        if (pol_reg == POL_RAND) begin
          rng_state = {1'b0, rng_state[LFSR_W-1:1]} ^ (rng_state[0] ? LFSR_TAPS : '0);
          w = 32'(rng_state) % n;
        end else if (pol_reg == POL_MRU) begin
          w = 0;
          for (i = 1; i < n; i++)
            if (dir_age[i] < dir_age[w]) w = i;
        end else begin
          // LRU, also taken by the unused policy code
          w = 0;
          for (i = 1; i < n; i++)
            if (dir_age[i] > dir_age[w]) w = i;
        end
        r.evicted = 1'b1;
        r.evicted_key = dir_tag[w];
      end
      dir_tag[w] = key;
      dir_valid[w] = 1'b1;
      dir_age[w] = 0;
    end
    r.hit = matched;
    r.way = w[WAY_W-1:0];
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Track register writes, predict accepted items, check accepted results
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_reg_write(cfg_index_i, cfg_data_i);
        reg_writes++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_lookups.size() == 0) begin
          err_count++;
          $display("%0t ns: result with none outstanding, expected none, actual way %0d",
                   $time, way_o);
        end else begin
          want = pending_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("way", 32'(want.way), 32'(way_o));
          check_field("evicted", 32'(want.evicted), 32'(evicted_o));
          check_field("evicted_key", 32'(want.evicted_key), 32'(evicted_key_o));
          check_field("hit_total", want.hit_total, hit_total_o);
          check_field("miss_total", want.miss_total, miss_total_o);
          lookups_done++;
          hits_done += int'(want.hit);
          evictions_done += int'(want.evicted);
        end
      end
      if (in_valid_i && in_ready_o)
        pending_lookups.insert(pending_lookups.size(), predict_lookup(key_i));
    end
  end

  // Receiver: long hold on request, else always ready or alternating ready and stall runs
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!sink_stalls_on) begin
      out_ready_i <= 1'b1;
    end else begin
      if (sink_run == 0) begin
        sink_open = !sink_open;
        sink_run = sink_open ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      sink_run--;
      out_ready_i <= sink_open;
    end
  end

  // Offer one item and hold it until accepted; insert a gap at burst end when gaps are on
  task automatic send_key(input logic [KEY_W-1:0] k);
    in_valid_i <= 1'b1;
    key_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    if (src_gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
    end
  endtask

  // Drop the input and wait until every result is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Fill two ways with the extreme keys and hit both
  task automatic test_basic_access();
    send_key(16'h0000);
    send_key(16'hFFFF);
    send_key(16'h0000);
    send_key(16'hFFFF);
  endtask

  // Evict under each policy code, zero seed, and an unknown register index
  task automatic test_policies();
    write_reg(CFG_WAYS, 16'hFFE2);
    send_key(16'hA5A5);
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_MRU));
    send_key(16'h5A5A);
    write_reg(CFG_POLICY, 16'hFFFE);
    write_reg(CFG_SEED, 16'h0000);
    send_key(16'h1234);
    send_key(16'h4321);
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_UNUSED));
    send_key(16'h8001);
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_RAND));
    write_reg(CFG_SEED, 16'hFFFF);
    send_key(16'h0F0F);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_key(16'hF0F0);
  endtask

  // Zero ways, oversize way count, and a key held twice once ways return
  task automatic test_way_limits();
    logic [KEY_W-1:0] twin_key;
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_LRU));
    write_reg(CFG_WAYS, 16'h0000);
    send_key(16'h7777);
    send_key(16'h7777);
    wait_idle();
    twin_key = dir_tag[1];
    // way 1 sits out of use while way 0 takes the same key
    send_key(twin_key);
    write_reg(CFG_WAYS, 16'h001F);
    send_key(twin_key);
    send_key(16'h0001);
  endtask

  // Hold the output off while items keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    src_gaps_on = 1'b0;
    hold_requests++;
    repeat (24) send_key(KEY_W'($urandom_range(0, 65535)));
    src_gaps_on = 1'b1;
  endtask

  // Random phases: new settings each phase, keys mostly from a working set
  task automatic test_random_traffic();
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    logic [WIU_W-1:0]    ways_val;
    logic [POLICY_W-1:0] pol_val;
    logic [LFSR_W-1:0]   seed_val;
    logic [31:0]         noise;
    int unsigned n;
    int unsigned ws;
    int unsigned pick;
    int ph;
    int k;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: ways_val = 5'd1;
        1: ways_val = 5'd16;
        2: ways_val = 5'd31;
        3: ways_val = 5'd0;
        default: ways_val = ($urandom_range(0, 3) == 0) ? WIU_W'($urandom_range(0, 31))
                                                          : WIU_W'($urandom_range(2, 8));
      endcase
      pol_val = (ph < 4) ? POLICY_W'(ph) : POLICY_W'($urandom_range(0, 3));
      seed_val = (ph == 0) ? 16'hFFFF : ((ph == 1) ? 16'h0000 : LFSR_W'($urandom));
      noise = $urandom;
      write_reg(CFG_POLICY, {noise[13:0], pol_val});
      write_reg(CFG_WAYS, {noise[26:16], ways_val});
      write_reg(CFG_SEED, seed_val);
      if (ph % 3 == 0) write_reg(CFG_UNUSED, noise[31:16]);
      // every fourth phase runs with no idling on either side
      src_gaps_on = (ph % 4 != 3);
      sink_stalls_on = (ph % 4 != 3);
      for (k = 0; k < POOL_SIZE; k++) key_pool[k] = KEY_W'($urandom);
      n = (ways_val == '0) ? 1 : ((32'(ways_val) > WAYS) ? WAYS : 32'(ways_val));
      ws = n + $urandom_range(0, 3);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) send_key(key_pool[$urandom_range(0, ws - 1)]);
        else if (pick < 80) send_key(pick[0] ? 16'hFFFF : 16'h0000);
        else send_key(KEY_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_access();
    test_policies();
    test_way_limits();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d lookups: %0d hits, %0d misses, %0d evictions, %0d register writes.",
             lookups_done, hits_done, lookups_done - hits_done, evictions_done, reg_writes);
    $display("Exercised all policy codes, way counts 0 to 31, output hold-off.");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("%0t ns: run did not complete in time", $time);
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
hdl/acr_pkg.sv
hdl/acr_urem.sv
hdl/acr_dpath.sv
hdl/acr_ctrl.sv
hdl/assoc_cache_replacement_top.sv
hdl/acr_checker.sv
tb/assoc_cache_replacement_top_tb.sv
